### src/atem_pkg.sv
// Shared constants, types and helper functions for the tile edge-mask block.
// Used by the channel interfaces, the line RAM, the result queue, the top level
// and the checker.
package atem_pkg;

	// Line storage geometry
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MAX_KINDS  = 64;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);

	// Field widths
	localparam int KIND_W = 6;
	localparam int COL_W  = 8;
	localparam int ROW_W  = 8;
	localparam int DIM_W  = 9;
	localparam int MASK_W = 4;
	localparam int SET_W  = 64;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// Configuration reset values
	localparam logic [DIM_W-1:0]  MAP_WIDTH_RST  = DIM_W'(256);
	localparam logic [DIM_W-1:0]  MAP_HEIGHT_RST = DIM_W'(256);
	localparam logic [KIND_W-1:0] AIR_INDEX_RST  = KIND_W'(63);

	// Result queue
	localparam int OUT_DEPTH = 3;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	// Edge mask bit positions
	localparam int MASK_LEFT  = 0;
	localparam int MASK_DOWN  = 1;
	localparam int MASK_RIGHT = 2;
	localparam int MASK_UP    = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAP_WIDTH    = 3'd0,
		CFG_MAP_HEIGHT   = 3'd1,
		CFG_AIR_INDEX    = 3'd2,
		CFG_SIXTEEN_SET  = 3'd3,
		CFG_SINGLE_SET   = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		FUNC_TILE  = 1'b0,
		FUNC_FLUSH = 1'b1
	} func_t;

	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic              write_variant;
		logic [MASK_W-1:0] variant;
		logic              last_of_layer;
	} result_t;

	// Membership test of a tile kind in a per-kind bit set
	function automatic logic kind_has(input logic [SET_W-1:0] set, input logic [KIND_W-1:0] kind);
		logic hit;
		hit = 1'b0;
		if (int'(kind) < MAX_KINDS) begin
			hit = set[kind];
		end
		return hit;
	endfunction

endpackage

### src/atem_channels.sv
// Valid/ready channel interfaces for tile items and result items.
// Depends on atem_pkg for field widths.
interface atem_in_if;
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic [atem_pkg::KIND_W-1:0] tile_kind;

	modport source(output valid, output func, output tile_kind, input ready);
	modport sink(input valid, input func, input tile_kind, output ready);
endinterface

interface atem_out_if;
	logic                        valid;
	logic                        ready;
	logic [atem_pkg::COL_W-1:0]  col;
	logic [atem_pkg::ROW_W-1:0]  row;
	logic                        write_variant;
	logic [atem_pkg::MASK_W-1:0] variant;
	logic                        last_of_layer;

	modport source(output valid, output col, output row, output write_variant,
		output variant, output last_of_layer, input ready);
	modport sink(input valid, input col, input row, input write_variant,
		input variant, input last_of_layer, output ready);
endinterface

### src/atem_line_ram.sv
// Line store: one write port and two registered read ports.
// Depends on atem_pkg for depth and entry width.
module atem_line_ram (
	input  logic                          clk,
	input  logic                          we,
	input  logic [atem_pkg::ADDR_W-1:0]   waddr,
	input  logic [atem_pkg::KIND_W-1:0]   wdata,
	input  logic [atem_pkg::ADDR_W-1:0]   raddr_a,
	input  logic [atem_pkg::ADDR_W-1:0]   raddr_b,
	output logic [atem_pkg::KIND_W-1:0]   rdata_a,
	output logic [atem_pkg::KIND_W-1:0]   rdata_b
);

	logic [atem_pkg::KIND_W-1:0] mem [atem_pkg::MAX_WIDTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read ports, old data on a same-edge write
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

### src/atem_out_fifo.sv
// Small result queue between the evaluate stage and the result channel.
// Depends on atem_pkg for the result type and queue depth.
module atem_out_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  atem_pkg::result_t               push_data,
	input  logic                            pop,
	output logic                            valid,
	output atem_pkg::result_t               data,
	output logic [atem_pkg::OUT_CNT_W-1:0]  count
);

	atem_pkg::result_t                   entry_q [atem_pkg::OUT_DEPTH];
	logic [atem_pkg::OUT_PTR_W-1:0]      wr_ptr_q;
	logic [atem_pkg::OUT_PTR_W-1:0]      rd_ptr_q;
	logic [atem_pkg::OUT_CNT_W-1:0]      count_q;

	function automatic logic [atem_pkg::OUT_PTR_W-1:0] ptr_next(
		input logic [atem_pkg::OUT_PTR_W-1:0] ptr);
		logic [atem_pkg::OUT_PTR_W-1:0] nxt;
		nxt = ptr + atem_pkg::OUT_PTR_W'(1);
		if (ptr == atem_pkg::OUT_PTR_W'(atem_pkg::OUT_DEPTH - 1)) begin
			nxt = '0;
		end
		return nxt;
	endfunction

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + atem_pkg::OUT_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - atem_pkg::OUT_CNT_W'(1);
			end
		end
	end

	assign valid = (count_q != '0);
	assign data  = entry_q[rd_ptr_q];
	assign count = count_q;

endmodule

### src/autotile_edge_mask.sv
// Top level of the 4-neighbour tile edge-mask block: configuration registers,
// counters, two line RAMs with forwarding, mask evaluation and result queue.
// Depends on atem_pkg, atem_channels, atem_line_ram and atem_out_fifo.

// The layer streams in raster order, one tile item per cell, followed by one
// flush item per column; the block accepts one item every cycle while input
// ready is high. A cell's result leaves one row late, carried by the item for
// the cell below it (or by a flush item on the last row), and reaches the
// result channel through the evaluate stage registers and the result queue.
// Each item does one read-modify-write of the two line RAMs: reads at accept,
// writes in the next cycle, with the previous item's write forwarded. A
// three-entry result queue decouples the result channel, so input ready drops
// only once the queue and the evaluate stage hold three results between them.
// First-row tiles pass through the pipeline but push nothing; ignored tiles
// and flushes write and push nothing. No clearing pass follows reset.
module autotile_edge_mask (
	input  logic                              clk,
	input  logic                              arst_n,
	atem_in_if.sink                           tiles,
	atem_out_if.source                        results,
	input  logic                              cfg_we,
	input  logic [atem_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [atem_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW = atem_pkg::ADDR_W;
	localparam int KW = atem_pkg::KIND_W;
	localparam int DW = atem_pkg::DIM_W;
	localparam int CW = atem_pkg::OUT_CNT_W;

	// Configuration registers
	logic [DW-1:0]                  map_width_q;
	logic [DW-1:0]                  map_height_q;
	logic [KW-1:0]                  air_index_q;
	logic [atem_pkg::SET_W-1:0]     sixteen_set_q;
	logic [atem_pkg::SET_W-1:0]     single_set_q;

	// Position counters
	logic [AW-1:0]                  col_count_q;
	logic [DW-1:0]                  row_count_q;

	// Accept stage signals
	logic [DW-1:0]                  w_eff;
	logic [DW-1:0]                  h_eff;
	logic [AW-1:0]                  x;
	logic                           last_col;
	logic                           rows_done;
	logic                           accept;
	logic                           do_tile;
	logic                           do_flush;
	logic                           act;
	logic                           has_result;

	// Evaluate stage registers
	logic                           valid_s1;
	logic                           res_s1;
	logic [AW-1:0]                  x_s1;
	logic [atem_pkg::ROW_W-1:0]     row_s1;
	logic                           top_edge_s1;
	logic                           last_col_s1;
	logic                           flush_s1;
	logic [KW-1:0]                  kind_s1;
	logic                           hz_above_xm1_s1;
	logic                           hz_above_x_s1;
	logic                           hz_mid_x_s1;
	logic                           hz_mid_xp1_s1;
	logic [KW-1:0]                  fwd_above_s1;
	logic [KW-1:0]                  fwd_mid_s1;

	// RAM data
	logic [KW-1:0]                  above_rd_a;
	logic [KW-1:0]                  above_rd_b;
	logic [KW-1:0]                  mid_rd_a;
	logic [KW-1:0]                  mid_rd_b;

	// Evaluate stage signals
	logic [KW-1:0]                  above_xm1;
	logic [KW-1:0]                  above_x;
	logic [KW-1:0]                  mid_x;
	logic [KW-1:0]                  mid_xp1;
	logic [atem_pkg::MASK_W-1:0]    mask;
	logic                           mid_we;
	atem_pkg::result_t              result;

	// Result queue
	logic                           push;
	logic                           pop;
	logic [CW-1:0]                  q_count;
	atem_pkg::result_t              q_data;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q   <= atem_pkg::MAP_WIDTH_RST;
			map_height_q  <= atem_pkg::MAP_HEIGHT_RST;
			air_index_q   <= atem_pkg::AIR_INDEX_RST;
			sixteen_set_q <= '0;
			single_set_q  <= '0;
		end else if (cfg_we) begin
			unique case (atem_pkg::cfg_reg_t'(cfg_index))
				atem_pkg::CFG_MAP_WIDTH:   map_width_q   <= cfg_data[DW-1:0];
				atem_pkg::CFG_MAP_HEIGHT:  map_height_q  <= cfg_data[DW-1:0];
				atem_pkg::CFG_AIR_INDEX:   air_index_q   <= cfg_data[KW-1:0];
				atem_pkg::CFG_SIXTEEN_SET: sixteen_set_q <= cfg_data[atem_pkg::SET_W-1:0];
				atem_pkg::CFG_SINGLE_SET:  single_set_q  <= cfg_data[atem_pkg::SET_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp geometry and locate the current column
	always_comb begin
		w_eff = map_width_q;
		if (map_width_q == '0) begin
			w_eff = DW'(1);
		end else if (map_width_q > DW'(atem_pkg::MAX_WIDTH)) begin
			w_eff = DW'(atem_pkg::MAX_WIDTH);
		end
		h_eff = map_height_q;
		if (map_height_q == '0) begin
			h_eff = DW'(1);
		end else if (map_height_q > DW'(atem_pkg::MAX_HEIGHT)) begin
			h_eff = DW'(atem_pkg::MAX_HEIGHT);
		end
		x = col_count_q;
		if (DW'(col_count_q) >= w_eff) begin
			x = AW'(w_eff - DW'(1));
		end
	end

	assign last_col   = (DW'(x) + DW'(1)) >= w_eff;
	assign rows_done  = row_count_q >= h_eff;
	assign accept     = tiles.valid && tiles.ready;
	assign do_tile    = accept && (tiles.func == atem_pkg::FUNC_TILE) && !rows_done;
	assign do_flush   = accept && (tiles.func == atem_pkg::FUNC_FLUSH) && rows_done
		&& (row_count_q != '0);
	assign act        = do_tile || do_flush;
	assign has_result = do_flush || (do_tile && (row_count_q != '0));

	// Hold input while the queue plus the evaluate stage could overflow
	assign tiles.ready = ((CW + 1)'(q_count) + (CW + 1)'(res_s1))
		<= (CW + 1)'(atem_pkg::OUT_DEPTH - 1);

	// Advance column and row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= '0;
			row_count_q <= '0;
		end else if (act) begin
			if (last_col) begin
				col_count_q <= '0;
				if (do_tile) begin
					row_count_q <= row_count_q + DW'(1);
				end else begin
					row_count_q <= '0;
				end
			end else begin
				col_count_q <= x + AW'(1);
			end
		end
	end

	// Line RAMs: above holds the row before last, middle the row being emitted
	atem_line_ram u_above_ram (
		.clk     (clk),
		.we      (valid_s1),
		.waddr   (x_s1),
		.wdata   (mid_x),
		.raddr_a (x - AW'(1)),
		.raddr_b (x),
		.rdata_a (above_rd_a),
		.rdata_b (above_rd_b)
	);

	atem_line_ram u_mid_ram (
		.clk     (clk),
		.we      (mid_we),
		.waddr   (x_s1),
		.wdata   (kind_s1),
		.raddr_a (x),
		.raddr_b (x + AW'(1)),
		.rdata_a (mid_rd_a),
		.rdata_b (mid_rd_b)
	);

	assign mid_we = valid_s1 && !flush_s1;

	// Evaluate stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_s1   <= 1'b0;
		end else begin
			valid_s1 <= act;
			res_s1   <= has_result;
		end
	end

	// Evaluate stage payload and forwarding of the write in flight
	always_ff @(posedge clk) begin
		x_s1            <= x;
		row_s1          <= atem_pkg::ROW_W'(row_count_q - DW'(1));
		top_edge_s1     <= (row_count_q == DW'(1));
		last_col_s1     <= last_col;
		flush_s1        <= do_flush;
		kind_s1         <= tiles.tile_kind;
		hz_above_xm1_s1 <= valid_s1 && (x_s1 == (x - AW'(1)));
		hz_above_x_s1   <= valid_s1 && (x_s1 == x);
		hz_mid_x_s1     <= mid_we && (x_s1 == x);
		hz_mid_xp1_s1   <= mid_we && (x_s1 == (x + AW'(1)));
		fwd_above_s1    <= mid_x;
		fwd_mid_s1      <= kind_s1;
	end

	// Resolve neighbours against the forwarded write
	assign above_xm1 = hz_above_xm1_s1 ? fwd_above_s1 : above_rd_a;
	assign above_x   = hz_above_x_s1   ? fwd_above_s1 : above_rd_b;
	assign mid_x     = hz_mid_x_s1     ? fwd_mid_s1   : mid_rd_a;
	assign mid_xp1   = hz_mid_xp1_s1   ? fwd_mid_s1   : mid_rd_b;

	// Build the edge mask and classify the kind
	always_comb begin
		mask = '0;
		mask[atem_pkg::MASK_LEFT]  = (x_s1 == '0) || (above_xm1 != mid_x);
		mask[atem_pkg::MASK_DOWN]  = flush_s1 || (kind_s1 != mid_x);
		mask[atem_pkg::MASK_RIGHT] = last_col_s1 || (mid_xp1 != mid_x);
		mask[atem_pkg::MASK_UP]    = top_edge_s1 || (above_x != mid_x);

		result.col           = atem_pkg::COL_W'(x_s1);
		result.row           = row_s1;
		result.write_variant = (mid_x != air_index_q)
			&& !atem_pkg::kind_has(single_set_q, mid_x);
		result.variant       = '0;
		if (result.write_variant && atem_pkg::kind_has(sixteen_set_q, mid_x)) begin
			result.variant = mask;
		end
		result.last_of_layer = flush_s1 && last_col_s1;
	end

	assign push = valid_s1 && res_s1;
	assign pop  = results.valid && results.ready;

	atem_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (result),
		.pop       (pop),
		.valid     (results.valid),
		.data      (q_data),
		.count     (q_count)
	);

	assign results.col           = q_data.col;
	assign results.row           = q_data.row;
	assign results.write_variant = q_data.write_variant;
	assign results.variant       = q_data.variant;
	assign results.last_of_layer = q_data.last_of_layer;

endmodule

### src/atem_checker.sv
// Port-level checks for the tile edge-mask block, bound to its top level.
// Depends on atem_pkg for field widths.
module atem_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [atem_pkg::COL_W-1:0]   col,
	input logic [atem_pkg::ROW_W-1:0]   row,
	input logic                         write_variant,
	input logic [atem_pkg::MASK_W-1:0]  variant,
	input logic                         last_of_layer
);

	localparam int PEND_W = 16;

	logic              in_acc;
	logic              out_acc;
	logic [PEND_W-1:0] pending_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Count input transactions not yet matched by a result transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			if (pending_q != '1) begin
				pending_q <= pending_q + PEND_W'(1);
			end
		end else if (out_acc && !in_acc) begin
			if (pending_q != '0) begin
				pending_q <= pending_q - PEND_W'(1);
			end
		end
	end

	a_out_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_out_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({col, row, write_variant, variant, last_of_layer}))
		else $error("result payload changed while stalled");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready with no result waiting");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (pending_q != '0))
		else $error("result transaction without an earlier input transaction");

endmodule

bind autotile_edge_mask atem_checker u_atem_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (tiles.valid),
	.in_ready      (tiles.ready),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.col           (results.col),
	.row           (results.row),
	.write_variant (results.write_variant),
	.variant       (results.variant),
	.last_of_layer (results.last_of_layer)
);

### bench/tb_autotile_edge_mask.sv
// Self-checking bench for autotile_edge_mask: streams tile layers and flush items,
// predicts each cell's edge mask in a scoreboard class and compares every result.
// Depends on atem_pkg, the atem_channels interfaces and the autotile_edge_mask RTL.
`timescale 1ns / 1ps

module tb_autotile_edge_mask;
	import atem_pkg::*;

	localparam int RESET_CYCLES  = 5;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 1000;
	localparam int ITEM_TARGET   = 950;
	localparam int REPORT_LIMIT  = 10;
	localparam int CFG_SPARE     = int'(CFG_SINGLE_SET) + 1;

	// Tracks line stores, counters and registers; queues the cells each item releases
	class edge_mask_scoreboard;
		logic [KIND_W-1:0] above_row [MAX_WIDTH];
		logic [KIND_W-1:0] middle_row [MAX_WIDTH];
		int unsigned       col_pos;
		int unsigned       row_pos;
		logic [DIM_W-1:0]  width_reg;
		logic [DIM_W-1:0]  height_reg;
		logic [KIND_W-1:0] air_reg;
		logic [SET_W-1:0]  sixteen_reg;
		logic [SET_W-1:0]  single_reg;
		result_t           expected_cells [$];
		int unsigned       tiles_used;
		int unsigned       flushes_used;
		int unsigned       items_ignored;
		int unsigned       cells_checked;
		int unsigned       layers_done;
		int unsigned       failures;

		function new();
			foreach (above_row[i]) begin
				above_row[i] = '0;
				middle_row[i] = '0;
			end
			col_pos = 0;
			row_pos = 0;
			width_reg = MAP_WIDTH_RST;
			height_reg = MAP_HEIGHT_RST;
			air_reg = AIR_INDEX_RST;
			sixteen_reg = '0;
			single_reg = '0;
			tiles_used = 0;
			flushes_used = 0;
			items_ignored = 0;
			cells_checked = 0;
			layers_done = 0;
			failures = 0;
		endfunction

		function int unsigned used_width();
			int unsigned w;
			w = width_reg;
			if (w < 1) w = 1;
			if (w > MAX_WIDTH) w = MAX_WIDTH;
			return w;
		endfunction

		function int unsigned used_height();
			int unsigned h;
			h = height_reg;
			if (h < 1) h = 1;
			if (h > MAX_HEIGHT) h = MAX_HEIGHT;
			return h;
		endfunction

		function bit awaiting_flush();
			return row_pos >= used_height();
		endfunction

		function int unsigned pending();
			return expected_cells.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_MAP_WIDTH: width_reg = data[DIM_W-1:0];
				CFG_MAP_HEIGHT: height_reg = data[DIM_W-1:0];
				CFG_AIR_INDEX: air_reg = data[KIND_W-1:0];
				CFG_SIXTEEN_SET: sixteen_reg = data;
				CFG_SINGLE_SET: single_reg = data;
				default: ;
			endcase
		endfunction

		function bit in_set(logic [SET_W-1:0] set, logic [KIND_W-1:0] kind);
			if (int'(kind) >= MAX_KINDS) return 1'b0;
			return set[kind];
		endfunction

		// Build the result for column x of row r from the stores and the cell below
		function result_t edge_mask(int unsigned x, int unsigned r, int unsigned w,
				bit has_below, logic [KIND_W-1:0] below, bit last);
			logic [KIND_W-1:0] c;
			logic [MASK_W-1:0] mask;
			result_t res;
			c = middle_row[x];
			mask = '0;
			if (x == 0) mask[MASK_LEFT] = 1'b1;
			else if (above_row[x-1] != c) mask[MASK_LEFT] = 1'b1;
			if (!has_below || below != c) mask[MASK_DOWN] = 1'b1;
			if (x + 1 >= w) mask[MASK_RIGHT] = 1'b1;
			else if (middle_row[x+1] != c) mask[MASK_RIGHT] = 1'b1;
			if (r == 0) mask[MASK_UP] = 1'b1;
			else if (above_row[x] != c) mask[MASK_UP] = 1'b1;
			res.col = COL_W'(x);
			res.row = ROW_W'(r);
			res.write_variant = 1'b0;
			res.variant = '0;
			res.last_of_layer = last;
			// Air wins over single-variant, which wins over sixteen-variant
			if (c != air_reg && !in_set(single_reg, c)) begin
				res.write_variant = 1'b1;
				if (in_set(sixteen_reg, c)) res.variant = mask;
			end
			return res;
		endfunction

		// Advance the stores for one accepted item and queue the cell it releases
		function void note_input(func_t func, logic [KIND_W-1:0] kind);
			int unsigned w;
			int unsigned h;
			int unsigned x;
			bit last;
			w = used_width();
			h = used_height();
			x = col_pos;
			if (x >= w) x = w - 1;
			if (func == FUNC_TILE) begin
				if (row_pos >= h) begin
					items_ignored++;
					return;
				end
				tiles_used++;
				if (row_pos >= 1)
					expected_cells.push_back(edge_mask(x, row_pos - 1, w, 1'b1, kind, 1'b0));
				above_row[x] = middle_row[x];
				middle_row[x] = kind;
				if (x + 1 >= w) begin
					col_pos = 0;
					row_pos++;
				end else begin
					col_pos = x + 1;
				end
			end else begin
				if (row_pos < h || row_pos == 0) begin
					items_ignored++;
					return;
				end
				flushes_used++;
				last = (x + 1 >= w);
				expected_cells.push_back(edge_mask(x, row_pos - 1, w, 1'b0, '0, last));
				above_row[x] = middle_row[x];
				if (last) begin
					col_pos = 0;
					row_pos = 0;
					layers_done++;
				end else begin
					col_pos = x + 1;
				end
			end
		endfunction

		function void report(string what, result_t want, result_t got);
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("mismatch %0d: %s: expected col %0d row %0d wr %0b var %h last %0b, %s",
					failures, what, want.col, want.row, want.write_variant, want.variant,
					want.last_of_layer,
					$sformatf("got col %0d row %0d wr %0b var %h last %0b", got.col, got.row,
						got.write_variant, got.variant, got.last_of_layer));
		endfunction

		// Compare one result transaction against the oldest queued cell
		function void check_result(result_t got);
			result_t want;
			string bad;
			if (expected_cells.size() == 0) begin
				report("result with nothing queued", '0, got);
				return;
			end
			want = expected_cells.pop_front();
			cells_checked++;
			bad = "";
			if (got.col !== want.col) bad = {bad, " col"};
			if (got.row !== want.row) bad = {bad, " row"};
			if (got.write_variant !== want.write_variant) bad = {bad, " write_variant"};
			if (got.variant !== want.variant) bad = {bad, " variant"};
			if (got.last_of_layer !== want.last_of_layer) bad = {bad, " last_of_layer"};
			if (bad != "") report({"wrong", bad}, want, got);
		endfunction

		function void close_out();
			if (expected_cells.size() != 0) begin
				failures += expected_cells.size();
				$display("%0d queued cells never came out", expected_cells.size());
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	atem_in_if  tile_ch ();
	atem_out_if result_ch ();

	autotile_edge_mask u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tiles     (tile_ch),
		.results   (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	edge_mask_scoreboard sb;
	bit                  src_calm;
	logic [KIND_W-1:0]   palette [4];
	int unsigned         settings_used;
	int unsigned         mid_changes;
	int unsigned         sink_stall;
	int unsigned         sink_calm;
	int unsigned         sink_roll;
	int unsigned         quiet_cycles;

	always #6 clk = ~clk;

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Place a value in the low bits of a register word with random bits above
	function automatic logic [CFG_DATA_W-1:0] pad_word(int unsigned v, int unsigned bits);
		logic [CFG_DATA_W-1:0] word;
		logic [CFG_DATA_W-1:0] low_mask;
		word = {$urandom, $urandom};
		low_mask = (64'd1 << bits) - 1;
		word = (word & ~low_mask) | (CFG_DATA_W'(v) & low_mask);
		return word;
	endfunction

	// Offer one tile transaction and hold it until accepted
	task automatic send_item(func_t func, logic [KIND_W-1:0] kind);
		int unsigned gap;
		gap = src_calm ? 0 : pick_gap();
		if (gap != 0) begin
			tile_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tile_ch.valid <= 1'b1;
		tile_ch.func <= func;
		tile_ch.tile_kind <= kind;
		do @(posedge clk); while (!tile_ch.ready);
		sb.note_input(func, kind);
	endtask

	// Drop valid, drain all queued cells, then let the pipeline empty
	task automatic settle();
		tile_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leave write enable high; the caller lowers it after the last write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic apply_settings(int unsigned w, int unsigned h, logic [KIND_W-1:0] air,
			logic [SET_W-1:0] sixteen_kinds, logic [SET_W-1:0] single_kinds);
		settle();
		write_reg(CFG_MAP_WIDTH, pad_word(w, DIM_W));
		write_reg(CFG_MAP_HEIGHT, pad_word(h, DIM_W));
		write_reg(CFG_AIR_INDEX, pad_word(air, KIND_W));
		write_reg(CFG_SIXTEEN_SET, sixteen_kinds);
		write_reg(CFG_SINGLE_SET, single_kinds);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Stream one layer; a few items go to the wrong phase and are dropped by the block
	task automatic stream_layer(bit mid_cfg);
		int unsigned start_layers;
		int unsigned split_at;
		bit          changed;
		func_t       func;
		logic [KIND_W-1:0] kind;
		start_layers = sb.layers_done;
		split_at = $urandom_range(0, sb.used_width() - 1);
		changed = !mid_cfg;
		while (sb.layers_done == start_layers) begin
			// Retune the block partway through the first row
			if (!changed && sb.row_pos == 0 && sb.col_pos >= split_at) begin
				settle();
				write_reg(CFG_MAP_WIDTH, pad_word($urandom_range(1, 12), DIM_W));
				write_reg(CFG_MAP_HEIGHT, pad_word($urandom_range(1, 5), DIM_W));
				write_reg(CFG_AIR_INDEX, pad_word(palette[$urandom_range(0, 3)], KIND_W));
				write_reg(CFG_SIXTEEN_SET, {$urandom, $urandom});
				cfg_we <= 1'b0;
				changed = 1'b1;
				mid_changes++;
			end
			func = sb.awaiting_flush() ? FUNC_FLUSH : FUNC_TILE;
			if ($urandom_range(0, 99) < 8) func = (func == FUNC_FLUSH) ? FUNC_TILE : FUNC_FLUSH;
			if ($urandom_range(0, 4) == 0) kind = KIND_W'($urandom);
			else kind = palette[$urandom_range(0, 3)];
			send_item(func, kind);
		end
	endtask

	// Result side: check every transaction, stall at random with calm stretches
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_result({result_ch.col, result_ch.row, result_ch.write_variant,
				result_ch.variant, result_ch.last_of_layer});
		if (sink_calm != 0) begin
			sink_calm <= sink_calm - 1;
			result_ch.ready <= 1'b1;
		end else if (sink_stall != 0) begin
			sink_stall <= sink_stall - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
			sink_roll = $urandom_range(0, 99);
			if (sink_roll < 2) sink_calm <= $urandom_range(50, 300);
			else if (sink_roll < 25) sink_stall <= pick_gap();
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((tile_ch.valid && tile_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	logic [KIND_W-1:0] layer_a [9];
	int unsigned       phase;
	int unsigned       w_pick;
	int unsigned       h_pick;
	int unsigned       layer_count;
	int unsigned       roll;
	int unsigned       directed_items;
	logic [KIND_W-1:0] air_pick;
	logic [SET_W-1:0]  sixteen_pick;
	logic [SET_W-1:0]  single_pick;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tile_ch.valid = 1'b0;
		tile_ch.func = FUNC_TILE;
		tile_ch.tile_kind = '0;
		result_ch.ready = 1'b0;
		sink_stall = 0;
		sink_calm = 0;
		quiet_cycles = 0;
		settings_used = 0;
		mid_changes = 0;
		src_calm = 1'b0;
		sb = new();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: 3x3 layer covering air, single, both-set, sixteen and plain kinds
		apply_settings(3, 3, 6'd5, 64'h8000_0000_0000_0015, 64'h0000_0000_0000_0018);
		@(posedge clk);
		for (int i = CFG_SPARE; i < (1 << CFG_IDX_W); i++)
			write_reg(CFG_IDX_W'(i), {$urandom, $urandom});
		cfg_we <= 1'b0;
		layer_a = '{6'd63, 6'd63, 6'd5, 6'd0, 6'd63, 6'd4, 6'd3, 6'd1, 6'd2};
		for (int i = 0; i < 9; i++) begin
			// A flush before the rows are in is dropped
			if (i == 3) send_item(FUNC_FLUSH, 6'd0);
			send_item(FUNC_TILE, layer_a[i]);
		end
		// A tile once all rows are in is dropped
		send_item(FUNC_TILE, 6'd63);
		repeat (3) send_item(FUNC_FLUSH, 6'd63);

		// Directed: shrink width and move air while the first row is streaming
		apply_settings(4, 2, 6'd63, {SET_W{1'b1}}, '0);
		send_item(FUNC_TILE, 6'd7);
		send_item(FUNC_TILE, 6'd7);
		settle();
		write_reg(CFG_MAP_WIDTH, pad_word(2, DIM_W));
		write_reg(CFG_AIR_INDEX, pad_word(7, KIND_W));
		cfg_we <= 1'b0;
		mid_changes++;
		send_item(FUNC_TILE, 6'd0);
		send_item(FUNC_TILE, 6'd7);
		send_item(FUNC_TILE, 6'd0);
		send_item(FUNC_FLUSH, 6'd0);
		send_item(FUNC_FLUSH, 6'd0);
		directed_items = sb.tiles_used + sb.flushes_used;

		// Random phases: widest row, tallest column, clamped minimum, then small layers
		phase = 0;
		while (sb.tiles_used + sb.flushes_used < directed_items + ITEM_TARGET) begin
			layer_count = $urandom_range(1, 3);
			case (phase)
				0: begin
					w_pick = 9'h1FF;
					h_pick = 1;
					layer_count = 1;
				end
				1: begin
					w_pick = 1;
					h_pick = 300;
					layer_count = 1;
				end
				2: begin
					w_pick = 0;
					h_pick = 0;
				end
				default: begin
					roll = $urandom_range(0, 99);
					if (roll < 70) w_pick = $urandom_range(1, 6);
					else if (roll < 90) w_pick = $urandom_range(7, 16);
					else w_pick = $urandom_range(17, 40);
					h_pick = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
				end
			endcase
			roll = $urandom_range(0, 99);
			if (roll < 15) air_pick = '0;
			else if (roll < 30) air_pick = {KIND_W{1'b1}};
			else air_pick = KIND_W'($urandom);
			roll = $urandom_range(0, 99);
			if (roll < 10) sixteen_pick = '0;
			else if (roll < 20) sixteen_pick = {SET_W{1'b1}};
			else sixteen_pick = {$urandom, $urandom};
			roll = $urandom_range(0, 99);
			if (roll < 15) single_pick = '0;
			else if (roll < 22) single_pick = {SET_W{1'b1}};
			else single_pick = {$urandom, $urandom} & {$urandom, $urandom};
			src_calm = ($urandom_range(0, 3) == 0);
			apply_settings(w_pick, h_pick, air_pick, sixteen_pick, single_pick);
			// Few kinds per layer so neighbors often match
			palette[0] = air_pick;
			for (int i = 1; i < 4; i++) palette[i] = KIND_W'($urandom);
			for (int n = 0; n < layer_count; n++)
				stream_layer(phase >= 3 && $urandom_range(0, 5) == 0);
			phase++;
		end

		settle();
		sb.close_out();
		$display("covered %0d tile and %0d flush transactions (%0d dropped) in %0d layers",
			sb.tiles_used, sb.flushes_used, sb.items_ignored, sb.layers_done);
		$display("%0d register settings, %0d mid-layer changes, %0d results checked, %0d errors",
			settings_used, mid_changes, sb.cells_checked, sb.failures);
		if (sb.failures == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
